[rtl/sact_pkg.sv]
// ----------------------------------------------------------------------------
// sact_pkg
// Shared types and constants for the sensor alert cooldown table.
// ----------------------------------------------------------------------------
package sact_pkg;

  localparam int NODES  = 16;
  localparam int SLOT_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CNT_W  = $clog2(NODES + 1);

  typedef struct packed {
    logic [15:0] addr;
    logic [31:0] alert_time;
    logic [7:0]  severity;
    logic [15:0] tilt;
    logic [31:0] tilt_time;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef enum logic [1:0] {
    OP_EVENT     = 2'd0,
    OP_TELEMETRY = 2'd1,
    OP_UPLINK    = 2'd2,
    OP_UNUSED    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_TILT  = 2'd2
  } kind_t;

  localparam logic [2:0] REG_TILT_LIMIT   = 3'd0;
  localparam logic [2:0] REG_RATE_LIMIT   = 3'd1;
  localparam logic [2:0] REG_MIN_SEVERITY = 3'd2;
  localparam logic [2:0] REG_COOLDOWN     = 3'd3;
  localparam logic [2:0] REG_LINK_GRACE   = 3'd4;

  localparam logic [15:0] RST_TILT_LIMIT   = 16'd2000;
  localparam logic [21:0] RST_RATE_LIMIT   = 22'd150;
  localparam logic [7:0]  RST_MIN_SEVERITY = 8'd2;
  localparam logic [19:0] RST_COOLDOWN     = 20'd1200;
  localparam logic [19:0] RST_LINK_GRACE   = 20'd300;

  localparam logic [31:0] MIN_RATE_GAP  = 32'd60;
  localparam logic [27:0] SEC_PER_HOUR  = 28'd3600;
  localparam logic [15:0] TILT_MAX      = 16'hFFFF;
  localparam logic [7:0]  TILT_SEVERITY = 8'd2;
  localparam logic [4:0]  ROOT_STEPS    = 5'd19;
  localparam logic [4:0]  DIV_STEPS     = 5'd28;

endpackage

[rtl/sensor_alert_cooldown_table_core.sv]
// ----------------------------------------------------------------------------
// sensor_alert_cooldown_table_core
// Per-source alert gating table with cooldown and a local tilt alert rule.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives exactly one result. An
// uplink note or an unused op goes straight to the result. Alert events, and
// telemetry frames while the link is down, walk the slot table in RAM, one
// entry a cycle. Such a telemetry frame then adds a bit-serial square root
// and, when the rate rule applies, a serial divider. A finished result waits
// in the output register while the next request is taken. Slot entries are
// cleared at reset by valid bits.
module sensor_alert_cooldown_table_core
  import sact_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // source, now, severity, code, event_value, event_threshold,
  // pitch, roll, zero pad
  input  logic [167:0] s_tdata,
  // op
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // alert_source, alert_severity, alert_code, alert_value, alert_threshold,
  // sent_total, suppressed_total
  output logic [159:0] m_tdata,
  // send, alert_kind
  output logic [2:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  typedef enum logic [3:0] {
    IDLE, DISPATCH, WALK, PICK, SQ, SUM, ROOT, RCHK, DIVIDE, JUDGE, GATE, FINISH
  } state_t;

  state_t state;

  logic [15:0] tilt_limit;
  logic [21:0] tilt_rate_limit;
  logic [7:0]  minimum_severity;
  logic [19:0] cooldown_seconds;
  logic [19:0] link_grace_seconds;

  op_t                op_q;
  logic [15:0]        src_q;
  logic [31:0]        now_q;
  logic [7:0]         sev_q;
  logic [7:0]         code_q;
  logic [31:0]        val_q;
  logic [31:0]        thr_q;
  logic signed [18:0] pitch_q;
  logic signed [18:0] roll_q;

  logic [31:0] uplink_ok_time;
  logic [31:0] sent_count;
  logic [31:0] suppressed_count;
  logic [NODES-1:0] slot_valid;

  logic [CNT_W-1:0]  cnt;
  logic [SLOT_W-1:0] idx_q;
  logic              rd_ok;
  logic              found;
  logic [SLOT_W-1:0] hit_idx;
  slot_t             hit_row;
  logic              have_free;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] oldest_idx;
  logic [31:0]       oldest_time;
  logic              walked;

  slot_t             row;
  logic [SLOT_W-1:0] slot_idx;

  logic signed [37:0] psq;
  logic signed [37:0] rsq;
  logic [37:0]        rad;
  logic [18:0]        root;
  logic [20:0]        rem;
  logic [4:0]         step;
  logic [15:0]        tilt_q;

  logic        rate_ok;
  logic [27:0] num;
  logic [31:0] dt;
  logic [27:0] quot;
  logic [31:0] drem;

  logic        send_q;
  kind_t       res_kind;
  logic [7:0]  res_sev;
  logic [7:0]  res_code;
  logic [31:0] res_val;
  logic [31:0] res_thr;

  logic             ram_we;
  logic [SLOT_BITS-1:0] ram_rdata;
  slot_t            rd_row;
  logic             out_free;
  logic             cfg_write;

  logic [22:0] root_rs;
  logic [22:0] root_trial;
  logic        root_ge;
  logic [32:0] div_ds;
  logic        div_ge;
  logic [16:0] tilt_diff;
  logic [15:0] tilt_now;
  logic [31:0] lt;
  logic [7:0]  gate_sev;
  logic        gate_supp;
  logic        link_down;

  assign s_tready  = (state == IDLE);
  assign pready    = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign ram_we    = (state == FINISH) && walked && out_free;
  assign rd_row    = slot_valid[idx_q] ? slot_t'(ram_rdata) : '0;

  sact_ram #(.WIDTH(SLOT_BITS), .DEPTH(NODES)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_idx),
    .wdata (row),
    .raddr (cnt[SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (paddr[4:2])
      REG_TILT_LIMIT:   prdata = {16'd0, tilt_limit};
      REG_RATE_LIMIT:   prdata = {10'd0, tilt_rate_limit};
      REG_MIN_SEVERITY: prdata = {24'd0, minimum_severity};
      REG_COOLDOWN:     prdata = {12'd0, cooldown_seconds};
      REG_LINK_GRACE:   prdata = {12'd0, link_grace_seconds};
      default:          prdata = 32'd0;
    endcase
  end

  always_comb begin
    root_rs    = {rem, rad[37:36]};
    root_trial = {2'b00, root, 2'b01};
    root_ge    = root_rs >= root_trial;
    div_ds     = {drem, num[27]};
    div_ge     = div_ds >= {1'b0, dt};
    tilt_now   = (root[18:16] != 3'd0) ? TILT_MAX : root[15:0];
    tilt_diff  = {1'b0, tilt_now} - {1'b0, row.tilt};
    lt         = row.tilt_time;
    gate_sev   = (op_q == OP_EVENT) ? sev_q : TILT_SEVERITY;
    gate_supp  = (gate_sev < minimum_severity) ||
                 ((row.alert_time != 32'd0) && (now_q >= row.alert_time) &&
                  ((now_q - row.alert_time) < {12'd0, cooldown_seconds}) &&
                  (gate_sev <= row.severity));
    link_down  = (uplink_ok_time == 32'd0) ||
                 ((now_q >= uplink_ok_time) &&
                  ((now_q - uplink_ok_time) >= {12'd0, link_grace_seconds}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= IDLE;
      tilt_limit         <= RST_TILT_LIMIT;
      tilt_rate_limit    <= RST_RATE_LIMIT;
      minimum_severity   <= RST_MIN_SEVERITY;
      cooldown_seconds   <= RST_COOLDOWN;
      link_grace_seconds <= RST_LINK_GRACE;
      uplink_ok_time     <= 32'd0;
      sent_count         <= 32'd0;
      suppressed_count   <= 32'd0;
      slot_valid         <= '0;
      m_tvalid           <= 1'b0;
      rd_ok              <= 1'b0;
      walked             <= 1'b0;
      send_q             <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (paddr[4:2])
          REG_TILT_LIMIT:   tilt_limit         <= pwdata[15:0];
          REG_RATE_LIMIT:   tilt_rate_limit    <= pwdata[21:0];
          REG_MIN_SEVERITY: minimum_severity   <= pwdata[7:0];
          REG_COOLDOWN:     cooldown_seconds   <= pwdata[19:0];
          REG_LINK_GRACE:   link_grace_seconds <= pwdata[19:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && state != FINISH) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (s_tvalid) begin
            op_q    <= op_t'(s_tuser);
            src_q   <= s_tdata[15:0];
            now_q   <= s_tdata[47:16];
            sev_q   <= s_tdata[55:48];
            code_q  <= s_tdata[63:56];
            val_q   <= s_tdata[95:64];
            thr_q   <= s_tdata[127:96];
            pitch_q <= s_tdata[146:128];
            roll_q  <= s_tdata[165:147];
            state   <= DISPATCH;
          end
        end
        DISPATCH: begin
          send_q    <= 1'b0;
          walked    <= (op_q == OP_EVENT) || ((op_q == OP_TELEMETRY) && link_down);
          rd_ok     <= 1'b0;
          found     <= 1'b0;
          have_free <= 1'b0;
          cnt       <= '0;
          case (op_q)
            OP_EVENT: begin
              state  <= WALK;
            end
            OP_TELEMETRY: begin
              state  <= link_down ? WALK : FINISH;
            end
            OP_UPLINK: begin
              uplink_ok_time <= now_q;
              state          <= FINISH;
            end
            default: state <= FINISH;
          endcase
        end
        WALK: begin
          rd_ok <= cnt < CNT_W'(NODES);
          idx_q <= cnt[SLOT_W-1:0];
          if (rd_ok) begin
            if (!found && rd_row.addr == src_q) begin
              found   <= 1'b1;
              hit_idx <= idx_q;
              hit_row <= rd_row;
            end
            if (!have_free && rd_row.addr == 16'd0) begin
              have_free <= 1'b1;
              free_idx  <= idx_q;
            end
            if (idx_q == '0 || rd_row.alert_time < oldest_time) begin
              oldest_idx  <= idx_q;
              oldest_time <= rd_row.alert_time;
            end
          end
          if (cnt == CNT_W'(NODES)) begin
            state <= PICK;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        PICK: begin
          slot_idx <= found ? hit_idx : (have_free ? free_idx : oldest_idx);
          if (found) begin
            row <= hit_row;
          end else begin
            row <= {src_q, {(SLOT_BITS-16){1'b0}}};
          end
          res_kind <= KIND_EVENT;
          res_sev  <= sev_q;
          res_code <= code_q;
          res_val  <= val_q;
          res_thr  <= thr_q;
          state    <= (op_q == OP_EVENT) ? GATE : SQ;
        end
        SQ: begin
          psq   <= pitch_q * pitch_q;
          rsq   <= roll_q * roll_q;
          state <= SUM;
        end
        SUM: begin
          rad   <= unsigned'(psq) + unsigned'(rsq);
          root  <= '0;
          rem   <= '0;
          step  <= '0;
          state <= ROOT;
        end
        ROOT: begin
          rem  <= root_ge ? 21'(root_rs - root_trial) : root_rs[20:0];
          root <= {root[17:0], root_ge};
          rad  <= {rad[35:0], 2'b00};
          step <= step + 1'b1;
          if (step == ROOT_STEPS - 1'b1) begin
            state <= RCHK;
          end
        end
        RCHK: begin
          tilt_q  <= tilt_now;
          dt      <= now_q - lt;
          num     <= 28'(tilt_diff[15:0]) * SEC_PER_HOUR;
          drem    <= '0;
          quot    <= '0;
          step    <= '0;
          rate_ok <= (lt != 32'd0) && (now_q > lt) && (tilt_rate_limit != 22'd0) &&
                     ((now_q - lt) >= MIN_RATE_GAP) && !tilt_diff[16] &&
                     (tilt_diff != 17'd0);
          state   <= DIVIDE;
        end
        DIVIDE: begin
          if (!rate_ok) begin
            state <= JUDGE;
          end else begin
            drem <= div_ge ? 32'(div_ds - {1'b0, dt}) : div_ds[31:0];
            quot <= {quot[26:0], div_ge};
            num  <= {num[26:0], 1'b0};
            step <= step + 1'b1;
            if (step == DIV_STEPS - 1'b1) begin
              state <= JUDGE;
            end
          end
        end
        JUDGE: begin
          row.tilt      <= tilt_q;
          row.tilt_time <= now_q;
          res_sev       <= TILT_SEVERITY;
          res_code      <= 8'd0;
          if (rate_ok && quot >= {6'd0, tilt_rate_limit}) begin
            res_kind <= KIND_RATE;
            res_val  <= {4'd0, quot};
            res_thr  <= {10'd0, tilt_rate_limit};
            state    <= GATE;
          end else if (tilt_limit != 16'd0 && tilt_q >= tilt_limit) begin
            res_kind <= KIND_TILT;
            res_val  <= {16'd0, tilt_q};
            res_thr  <= {16'd0, tilt_limit};
            state    <= GATE;
          end else begin
            state <= FINISH;
          end
        end
        GATE: begin
          if (gate_supp) begin
            suppressed_count <= suppressed_count + 32'd1;
          end else begin
            sent_count     <= sent_count + 32'd1;
            row.alert_time <= now_q;
            row.severity   <= gate_sev;
            send_q         <= 1'b1;
          end
          state <= FINISH;
        end
        FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (send_q) begin
              m_tuser <= {res_kind, 1'b1};
              m_tdata <= {suppressed_count, sent_count, res_thr, res_val,
                          res_code, res_sev, src_q};
            end else begin
              m_tuser <= 3'd0;
              m_tdata <= {suppressed_count, sent_count, 96'd0};
            end
            if (walked) begin
              slot_valid[slot_idx] <= 1'b1;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_one_count_per_gate: assert property (@(posedge clk) disable iff (rst)
    (sent_count != $past(sent_count) || suppressed_count != $past(suppressed_count))
      |-> $past(state) == GATE)
    else $error("alert counter moved outside gating");

  a_counts_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(sent_count != $past(sent_count) && suppressed_count != $past(suppressed_count)))
    else $error("alert both sent and suppressed");

  a_hit_matches: assert property (@(posedge clk) disable iff (rst)
    (state == PICK && found) |-> hit_row.addr == src_q)
    else $error("slot hit with wrong address");

  a_write_only_walked: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (op_q == OP_EVENT || op_q == OP_TELEMETRY))
    else $error("slot write for an op that does not touch the table");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == FINISH && out_free) |=> (m_tvalid && state == IDLE))
    else $error("result not presented on finish");

endmodule

[rtl/sact_ram.sv]
// ----------------------------------------------------------------------------
// sact_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[test/tb_sensor_alert_cooldown_table_core.sv]
// ----------------------------------------------------------------------------
// tb_sensor_alert_cooldown_table_core
// Self-checking bench for the alert cooldown table: a local model of the slot
// table, link state, tilt rules and gating predicts one result per request;
// stream traffic runs under several idle/stall mixes and register settings.
// ----------------------------------------------------------------------------
module tb_sensor_alert_cooldown_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sact_pkg::*;

  typedef struct packed {
    logic signed [18:0] roll;
    logic signed [18:0] pitch;
    logic signed [31:0] threshold;
    logic signed [31:0] value;
    logic [7:0]  code;
    logic [7:0]  severity;
    logic [31:0] now;
    logic [15:0] source;
  } req_t;

  typedef struct {
    req_t req;
    op_t  op;
  } item_t;

  typedef struct packed {
    logic [31:0] supp;
    logic [31:0] sent;
    logic [31:0] thr;
    logic [31:0] val;
    logic [7:0]  code;
    logic [7:0]  sev;
    logic [15:0] src;
  } res_t;

  typedef struct {
    res_t r;
    logic [2:0] user;
  } alert_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [167:0] s_tdata;
  logic [1:0] s_tuser;
  logic [159:0] m_tdata;
  logic [2:0] m_tuser;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  sensor_alert_cooldown_table_core u_dut (.*);

  // model state
  logic [15:0] t_addr [NODES];
  logic [31:0] t_atime [NODES];
  logic [7:0]  t_sev [NODES];
  logic [15:0] t_tilt [NODES];
  logic [31:0] t_ttime [NODES];
  logic [31:0] uplink_time, n_sent, n_supp;
  logic [15:0] c_tilt;
  logic [21:0] c_rate;
  logic [7:0]  c_minsev;
  logic [19:0] c_cool, c_grace;

  item_t  pending[$];
  alert_t expected_alerts[$];
  int errors, stall_pct, idle_pct, hold_cycles, idle_count;
  bit all_sent;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[31:0];
  endfunction

  function automatic int lookup_slot(logic [15:0] a);
    int pick, oldest;
    bit have_free;
    pick = 0;
    oldest = 0;
    have_free = 0;
    for (int i = 0; i < NODES; i++) begin
      if (t_addr[i] == a) return i;
      if (t_addr[i] == 0 && !have_free) begin
        have_free = 1;
        pick = i;
      end
      if (t_atime[i] < t_atime[oldest]) oldest = i;
    end
    if (!have_free) pick = oldest;
    t_addr[pick] = a;
    t_atime[pick] = 0;
    t_sev[pick] = 0;
    t_tilt[pick] = 0;
    t_ttime[pick] = 0;
    return pick;
  endfunction

  function automatic bit gate_alert(int s, logic [31:0] now, logic [7:0] sev);
    logic [31:0] last;
    last = t_atime[s];
    if (sev < c_minsev || (last != 0 && now >= last && (now - last) < c_cool &&
        sev <= t_sev[s])) begin
      n_supp++;
      return 0;
    end
    t_atime[s] = now;
    t_sev[s] = sev;
    n_sent++;
    return 1;
  endfunction

  function automatic alert_t predict_alert(item_t it);
    alert_t a;
    int s;
    bit fired, link_down;
    logic [63:0] sq;
    longint p, rl, rate;
    logic [31:0] mag, dt, now;
    logic [15:0] tilt;
    kind_t kind;
    a.r = '0;
    a.user = '0;
    now = it.req.now;
    kind = KIND_EVENT;
    case (it.op)
      OP_EVENT: begin
        s = lookup_slot(it.req.source);
        if (gate_alert(s, now, it.req.severity)) begin
          a.user = {KIND_EVENT, 1'b1};
          a.r.src = it.req.source;
          a.r.sev = it.req.severity;
          a.r.code = it.req.code;
          a.r.val = it.req.value;
          a.r.thr = it.req.threshold;
        end
      end
      OP_TELEMETRY: begin
        if (uplink_time == 0) link_down = 1;
        else if (now < uplink_time) link_down = 0;
        else link_down = (now - uplink_time) >= c_grace;
        if (link_down) begin
          s = lookup_slot(it.req.source);
          p = it.req.pitch;
          rl = it.req.roll;
          sq = p * p + rl * rl;
          mag = isqrt(sq);
          tilt = mag > 65535 ? 16'hFFFF : mag[15:0];
          fired = 0;
          if (t_ttime[s] != 0 && now > t_ttime[s] && c_rate != 0) begin
            dt = now - t_ttime[s];
            if (dt >= 60) begin
              rate = (longint'(tilt) - longint'(t_tilt[s])) * 3600 / longint'(dt);
              if (rate >= longint'(c_rate)) begin
                fired = 1;
                kind = KIND_RATE;
                a.r.val = rate[31:0];
                a.r.thr = 32'(c_rate);
              end
            end
          end
          if (!fired && c_tilt != 0 && tilt >= c_tilt) begin
            fired = 1;
            kind = KIND_TILT;
            a.r.val = 32'(tilt);
            a.r.thr = 32'(c_tilt);
          end
          t_tilt[s] = tilt;
          t_ttime[s] = now;
          if (fired && gate_alert(s, now, 8'd2)) begin
            a.user = {kind, 1'b1};
            a.r.src = it.req.source;
            a.r.sev = 8'd2;
          end
        end
      end
      OP_UPLINK: uplink_time = now;
      default: ;
    endcase
    if (!a.user[0]) begin
      a.r = '0;
      a.user = '0;
    end
    a.r.sent = n_sent;
    a.r.supp = n_supp;
    return a;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
        item_t it;
        it = pending.pop_front();
        expected_alerts.push_back(predict_alert(it));
        s_tdata <= {2'd0, it.req};
        s_tuser <= it.op;
        s_tvalid <= 1;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // receiver stall, with an optional long hold
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_alerts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h %h", m_tuser, m_tdata);
      end else begin
        alert_t e;
        e = expected_alerts.pop_front();
        if (e.user !== m_tuser || e.r !== m_tdata) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp user %h data %h, got user %h data %h",
                     e.user, e.r, m_tuser, m_tdata);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || all_sent)
      idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_TILT_LIMIT: c_tilt = v[15:0];
      REG_RATE_LIMIT: c_rate = v[21:0];
      REG_MIN_SEVERITY: c_minsev = v[7:0];
      REG_COOLDOWN: c_cool = v[19:0];
      default: c_grace = v[19:0];
    endcase
  endtask

  task automatic drain();
    while (pending.size() > 0 || expected_alerts.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic item_t make_item(op_t op, logic [15:0] src, logic [31:0] now,
                                      int pitch, int roll);
    item_t it;
    it.op = op;
    it.req.source = src;
    it.req.now = now;
    it.req.severity = 8'($urandom_range(255));
    it.req.code = 8'($urandom);
    it.req.value = $urandom;
    it.req.threshold = $urandom;
    it.req.pitch = 19'(pitch);
    it.req.roll = 19'(roll);
    return it;
  endfunction

  function automatic int rand_angle();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 180000 : -180000;
      1: return int'($urandom_range(8000)) - 4000;
      default: return int'($urandom_range(360000)) - 180000;
    endcase
  endfunction

  task automatic random_phase(int n, logic [31:0] t0);
    logic [31:0] clock_s;
    item_t it;
    clock_s = t0;
    for (int i = 0; i < n; i++) begin
      int k;
      k = $urandom_range(99);
      clock_s += $urandom_range(1) ? $urandom_range(120) : $urandom_range(2000);
      if (k < 3) clock_s -= $urandom_range(500);
      it = make_item(k < 40 ? OP_EVENT : k < 85 ? OP_TELEMETRY :
                     k < 96 ? OP_UPLINK : OP_UNUSED,
                     $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(24)),
                     $urandom_range(49) == 0 ? 32'($urandom) : clock_s,
                     rand_angle(), rand_angle());
      if ($urandom_range(9) == 0) it.req.severity = 8'($urandom_range(4));
      pending.push_back(it);
    end
  endtask

  initial begin
    item_t it;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    all_sent = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    s_tdata = 0;
    s_tuser = 0;
    for (int i = 0; i < NODES; i++) begin
      t_addr[i] = 0;
      t_atime[i] = 0;
      t_sev[i] = 0;
      t_tilt[i] = 0;
      t_ttime[i] = 0;
    end
    uplink_time = 0;
    n_sent = 0;
    n_supp = 0;
    c_tilt = RST_TILT_LIMIT;
    c_rate = RST_RATE_LIMIT;
    c_minsev = RST_MIN_SEVERITY;
    c_cool = RST_COOLDOWN;
    c_grace = RST_LINK_GRACE;
    rst = 1;
    repeat (5) @(posedge clk);
    rst <= 0;
    repeat (2) @(posedge clk);

    // directed: reset settings
    pending.push_back(make_item(OP_TELEMETRY, 16'd5, 32'd1000, 1000, 1000));
    pending.push_back(make_item(OP_TELEMETRY, 16'd5, 32'd1100, 180000, -180000));
    pending.push_back(make_item(OP_TELEMETRY, 16'd5, 32'd1120, -180000, 180000));
    pending.push_back(make_item(OP_TELEMETRY, 16'd5, 32'd1200, 0, 0));
    pending.push_back(make_item(OP_TELEMETRY, 16'd0, 32'd1300, 3000, 0));
    it = make_item(OP_EVENT, 16'd7, 32'd2000, 0, 0);
    it.req.severity = 8'd3;
    it.req.value = 32'h8000_0000;
    it.req.threshold = 32'h7FFF_FFFF;
    pending.push_back(it);
    it.req.now = 32'd2100;
    pending.push_back(it);
    it.req.severity = 8'd255;
    pending.push_back(it);
    it.req.severity = 8'd1;
    pending.push_back(it);
    it.req.now = 32'd1000;
    it.req.severity = 8'd200;
    pending.push_back(it);
    pending.push_back(make_item(OP_UPLINK, 16'd0, 32'd5000, 0, 0));
    pending.push_back(make_item(OP_TELEMETRY, 16'd9, 32'd5100, 50000, 0));
    pending.push_back(make_item(OP_TELEMETRY, 16'd9, 32'd4000, 50000, 0));
    pending.push_back(make_item(OP_TELEMETRY, 16'd9, 32'd5300, 50000, 0));
    pending.push_back(make_item(OP_UPLINK, 16'd0, 32'd0, 0, 0));
    pending.push_back(make_item(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, -1, -1));
    for (int i = 0; i < 18; i++)
      pending.push_back(make_item(OP_EVENT, 16'(100 + i), 32'(3000 + 7 * i), 0, 0));
    drain();

    // random phases under several settings and traffic mixes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_TILT_LIMIT, 32'd0);
          write_reg(REG_RATE_LIMIT, 32'd0);
          write_reg(REG_MIN_SEVERITY, 32'd0);
          write_reg(REG_COOLDOWN, 32'd0);
          write_reg(REG_LINK_GRACE, 32'd0);
        end
        1: begin
          write_reg(REG_TILT_LIMIT, 32'hFFFF);
          write_reg(REG_RATE_LIMIT, 32'h3FFFFF);
          write_reg(REG_MIN_SEVERITY, 32'hFF);
          write_reg(REG_COOLDOWN, 32'hFFFFF);
          write_reg(REG_LINK_GRACE, 32'hFFFFF);
        end
        default: begin
          write_reg(REG_TILT_LIMIT, $urandom_range(60000));
          write_reg(REG_RATE_LIMIT, $urandom_range(1) ? $urandom_range(400000)
                                                     : $urandom_range(4194303));
          write_reg(REG_MIN_SEVERITY, $urandom_range(6));
          write_reg(REG_COOLDOWN, $urandom_range(3000));
          write_reg(REG_LINK_GRACE, $urandom_range(1500));
        end
      endcase
      idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 1 ? 65 : 36) : 0;
      stall_pct = (ph % 4 == 2) ? 65 : (ph % 4 == 3) ? 36 : 0;
      random_phase(270, 32'($urandom_range(100000)) + 1);
      if (ph == 2) begin
        while (pending.size() > 200) @(posedge clk);
        hold_cycles <= 3000;
      end
      drain();
    end

    all_sent = 1;
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
